// File: design/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/tsc_pkg.sv
`default_nettype none
package tsc_pkg;

  localparam int unsigned STAMP_W = 64;
  localparam int unsigned CPU_W   = 3;
  localparam int unsigned ROUND_W = 16;
  localparam int unsigned NUM_W   = 81;
  localparam logic [ROUND_W-1:0] ROUND_LIMIT_RESET = 16'd1000;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [CPU_W-1:0]     cpu;
    logic [STAMP_W-1:0]   stamp;
    logic [CPU_W-1:0]     other_cpu;
    logic [STAMP_W-1:0]   other_stamp;
    logic                 round_end;
  } tsc_in_t;

  typedef struct packed {
    logic [STAMP_W-1:0]   difference;
    logic [CPU_W-1:0]     owner_cpu;
    logic                 ignored;
    logic [ROUND_W-1:0]   rounds_done;
  } tsc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QRD,
    ST_QSUB,
    ST_URD,
    ST_UMUL,
    ST_UNUM,
    ST_UDIV,
    ST_UWR,
    ST_OUT
  } tsc_state_t;

  typedef struct packed {
    logic                start;
    logic [NUM_W-1:0]    numer;
    logic [ROUND_W:0]    denom;
  } tsc_div_req_t;

endpackage
`default_nettype wire

// File: design/tsc_ram.sv
`default_nettype none
module tsc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/tsc_div.sv
`default_nettype none
// Restoring divider of magnitudes, one quotient bit per cycle.
module tsc_div
  import tsc_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst,
  input  tsc_pkg::tsc_div_req_t        req,
  output logic                         busy,
  output logic [tsc_pkg::STAMP_W-1:0]  quot
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   mag;
  logic               neg;
  logic [ROUND_W:0]   den;
  logic [ROUND_W+1:0] rem;
  logic [NUM_W-1:0]   q;
  logic [CNT_W-1:0]   cnt;
  logic [ROUND_W+1:0] trial;
  logic [NUM_W-1:0]   qn;

  assign mag   = req.numer[NUM_W-1] ? (~req.numer + 1'b1) : req.numer;
  assign trial = {rem[ROUND_W:0], num[NUM_W-1]};
  assign qn    = neg ? (~q + 1'b1) : q;
  assign quot  = qn[STAMP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
      num  <= mag;
      neg  <= req.numer[NUM_W-1];
      den  <= req.denom;
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      num <= {num[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: design/timestamp_skew_calibrator.sv
`default_nettype none
// Timestamp skew calibrator. Samples store one stamp per processor; a sample
// marked round_end folds the vector into a CPUS x CPUS skew matrix of running
// means. Queries return stamp - other_stamp - skew, modulo 2^64. A round end
// walks all CPUS*CPUS matrix entries through one bit-serial divider. Each item
// gives one result transfer; the next item is taken once that result has been
// transferred. The matrix lives in a one-port-read, one-port-write RAM; after
// reset a clearing pass writes one entry a cycle over all CPUS*CPUS entries
// before the first item is taken.
module timestamp_skew_calibrator #(
  parameter int unsigned CPUS = 8
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  tsc_pkg::tsc_in_t         in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output tsc_pkg::tsc_out_t        out_data,
  input  wire                      cfg_we,
  input  wire [15:0]               cfg_data
);
  import tsc_pkg::*;

  localparam int unsigned IW    = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int unsigned DEPTH = CPUS * CPUS;
  localparam int unsigned AW    = $clog2(DEPTH);

  tsc_state_t state, state_next;
  logic                clearing;
  logic [AW:0]         clr_cnt;
  logic [ROUND_W-1:0]  round_limit;
  logic [ROUND_W-1:0]  round_count;
  logic [STAMP_W-1:0]  svec [CPUS];
  tsc_in_t             item;
  logic [IW-1:0]       ui, uj;
  logic signed [NUM_W-1:0] prod;
  logic signed [NUM_W-1:0] numer_c;
  logic signed [NUM_W-1:0] numer_r;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [STAMP_W-1:0]  wdata, rdata;
  tsc_div_req_t        dreq;
  logic                dbusy;
  logic [STAMP_W-1:0]  dquot;

  logic                cpu_ok, ocpu_ok, last_entry;
  logic [STAMP_W-1:0]  dval;

  tsc_ram #(.WIDTH(STAMP_W), .DEPTH(DEPTH)) u_mat (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  tsc_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quot(dquot));

  assign cpu_ok     = {1'b0, item.cpu} < (CPU_W+1)'(CPUS);
  assign ocpu_ok    = {1'b0, item.other_cpu} < (CPU_W+1)'(CPUS);
  assign last_entry = (ui == IW'(CPUS-1)) && (uj == IW'(CPUS-1));
  assign dval       = svec[ui] - svec[uj];
  assign in_ready   = (state == ST_IDLE) && !clearing;

  always_comb begin
    raddr = AW'(ui * CPUS + uj);
    if (state == ST_QRD) begin
      raddr = AW'(item.cpu[IW-1:0] * CPUS + item.other_cpu[IW-1:0]);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(ui * CPUS + uj);
    wdata = dquot;
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_cnt[AW-1:0];
      wdata = STAMP_W'(1);
    end else if (state == ST_UWR) begin
      we = 1'b1;
    end
  end

  always_comb begin
    dreq.start = (state == ST_UNUM);
    dreq.numer = numer_r;
    dreq.denom = {1'b0, round_count} + 1'b1;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid && in_ready) begin
        if (in_data.kind == KIND_QUERY) begin
          state_next = ST_QRD;
        end else begin
          state_next = ST_OUT;
          if (round_count < round_limit && in_data.round_end) begin
            state_next = ST_URD;
          end
        end
      end
      ST_QRD:  state_next = ST_QSUB;
      ST_QSUB: state_next = ST_OUT;
      ST_URD:  state_next = ST_UMUL;
      ST_UMUL: state_next = ST_UNUM;
      ST_UNUM: state_next = ST_UDIV;
      ST_UDIV: if (!dbusy) begin
        state_next = ST_UWR;
      end
      ST_UWR:  state_next = last_entry ? ST_OUT : ST_URD;
      ST_OUT:  if (out_ready) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      clearing    <= 1'b1;
      clr_cnt     <= '0;
      round_limit <= ROUND_LIMIT_RESET;
      round_count <= '0;
      for (int k = 0; k < CPUS; k++) begin
        svec[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        round_limit <= cfg_data;
      end
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (AW+1)'(DEPTH-1)) begin
          clearing <= 1'b0;
        end
      end
      case (state)
        ST_IDLE: if (in_valid && in_ready) begin
          item                 <= in_data;
          ui                   <= '0;
          uj                   <= '0;
          out_data.owner_cpu   <= in_data.cpu;
          out_data.difference  <= '0;
          out_data.ignored     <= 1'b0;
          out_data.rounds_done <= round_count;
          if (in_data.kind == KIND_SAMPLE) begin
            if (round_count >= round_limit) begin
              out_data.ignored <= 1'b1;
            end else if ({1'b0, in_data.cpu} < (CPU_W+1)'(CPUS)) begin
              svec[in_data.cpu[IW-1:0]] <= in_data.stamp;
            end
          end
        end
        ST_QRD: ;
        ST_QSUB: begin
          out_data.difference <= item.stamp - item.other_stamp
                                 - ((cpu_ok && ocpu_ok) ? rdata : '0);
        end
        ST_URD: ;
        ST_UMUL: ;
        ST_UNUM: ;
        ST_UDIV: ;
        ST_UWR: begin
          if (last_entry) begin
            round_count          <= round_count + 1'b1;
            out_data.rounds_done <= round_count + 1'b1;
          end
          if (uj == IW'(CPUS-1)) begin
            uj <= '0;
            ui <= ui + 1'b1;
          end else begin
            uj <= uj + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // numerator: old*n + d, exact
  always_comb begin
    prod    = $signed({{(NUM_W-STAMP_W){rdata[STAMP_W-1]}}, rdata})
              * $signed({{(NUM_W-ROUND_W){1'b0}}, round_count});
    numer_c = prod + $signed({{(NUM_W-STAMP_W){dval[STAMP_W-1]}}, dval});
  end

  always_ff @(posedge clk) begin
    if (state == ST_UMUL) begin
      numer_r <= numer_c;
    end
  end
endmodule
`default_nettype wire

// File: design/tsc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tsc_checker (
  input wire               clk,
  input wire               rst,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input tsc_pkg::tsc_out_t out_data
);
  import tsc_pkg::*;

  `ASSERT_CLK(a_one_at_a_time, out_valid |-> !in_ready, "input taken while result pending")
  `ASSERT_CLK(a_accept_busy, in_valid && in_ready |=> !in_ready, "second input taken at once")
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data),
    "result changed before transfer")
  `ASSERT_CLK(a_query_flag, out_valid |-> !(out_data.ignored && out_data.difference != '0),
    "ignored sample with nonzero difference")
  `ASSERT_RST(a_reset_idle, rst |=> !out_valid, "result valid after reset")
endmodule

bind timestamp_skew_calibrator tsc_checker u_tsc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// File: sim/tb_timestamp_skew_calibrator.sv
`default_nettype none
module tb_timestamp_skew_calibrator;
  import tsc_pkg::*;

  localparam int NCPU = 8;
  localparam longint LIMIT_CYCLES = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tsc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tsc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  timestamp_skew_calibrator #(.CPUS(NCPU)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  logic [63:0] stamps [NCPU];
  logic [63:0] skew [NCPU*NCPU];
  logic [15:0] rounds;
  logic [15:0] limit;

  tsc_out_t pending [$];
  int mismatches = 0;
  int n_results = 0;
  int n_updates = 0;
  int n_ignored = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [63:0] running_mean(logic [63:0] old, logic [63:0] d,
                                               logic [15:0] n);
    logic signed [80:0] num;
    logic signed [80:0] q;
    num = $signed({{17{old[63]}}, old}) * $signed({65'd0, n})
        + $signed({{17{d[63]}}, d});
    q = num / $signed({64'd0, {1'b0, n} + 17'd1});
    return q[63:0];
  endfunction

  function automatic tsc_out_t predict_item(tsc_in_t it);
    tsc_out_t r;
    r = '0;
    r.owner_cpu = it.cpu;
    if (it.kind == KIND_SAMPLE) begin
      if (rounds >= limit) begin
        r.ignored = 1'b1;
      end else begin
        stamps[it.cpu] = it.stamp;
        if (it.round_end) begin
          for (int i = 0; i < NCPU; i++)
            for (int j = 0; j < NCPU; j++)
              skew[i*NCPU+j] = running_mean(skew[i*NCPU+j], stamps[i] - stamps[j],
                                            rounds);
          rounds = rounds + 16'd1;
        end
      end
    end else begin
      r.difference = it.stamp - it.other_stamp - skew[it.cpu*NCPU+it.other_cpu];
    end
    r.rounds_done = rounds;
    return r;
  endfunction

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        tsc_out_t e;
        n_results <= n_results + 1;
        if (pending.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          e = pending.pop_front();
          if (out_data.difference !== e.difference || out_data.owner_cpu !== e.owner_cpu ||
              out_data.ignored !== e.ignored || out_data.rounds_done !== e.rounds_done) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", e, out_data);
          end
        end
      end
    end
  end

  task automatic send_item(tsc_in_t it);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    pending.push_back(predict_item(it));
    if (it.kind == KIND_SAMPLE && it.round_end && !pending[$].ignored) n_updates++;
    if (pending[$].ignored) n_ignored++;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    // block is busy after a transfer
    @(posedge clk);
  endtask

  task automatic drain_and_write(logic [15:0] val);
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    limit = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic tsc_in_t make_sample(logic [2:0] c, logic [63:0] s, logic e);
    tsc_in_t it;
    it = '0;
    it.kind = KIND_SAMPLE;
    it.cpu = c;
    it.stamp = s;
    it.round_end = e;
    it.other_cpu = 3'($urandom());
    it.other_stamp = rand64();
    return it;
  endfunction

  function automatic tsc_in_t make_query(logic [2:0] c, logic [63:0] s,
                                         logic [2:0] oc, logic [63:0] os);
    tsc_in_t it;
    it.kind = KIND_QUERY;
    it.cpu = c;
    it.stamp = s;
    it.other_cpu = oc;
    it.other_stamp = os;
    it.round_end = 1'($urandom());
    return it;
  endfunction

  task automatic test_directed();
    send_item(make_query(3'd0, 64'd0, 3'd0, 64'd0));
    send_item(make_query(3'd7, '1, 3'd0, 64'd0));
    send_item(make_query(3'd0, 64'd0, 3'd7, '1));
    send_item(make_sample(3'd0, '1, 1'b0));
    send_item(make_sample(3'd7, 64'd0, 1'b0));
    send_item(make_sample(3'd3, 64'h8000_0000_0000_0000, 1'b1));
    send_item(make_query(3'd0, 64'd100, 3'd7, 64'd50));
    send_item(make_query(3'd7, 64'd100, 3'd3, 64'd50));
    send_item(make_sample(3'd1, 64'h7fff_ffff_ffff_ffff, 1'b0));
    send_item(make_sample(3'd7, '1, 1'b1));
    send_item(make_query(3'd1, '1, 3'd7, '1));
    send_item(make_query(3'd3, rand64(), 3'd1, rand64()));
  endtask

  task automatic test_limit_extremes();
    // limit at or below the round count: every sample ignored; then 65535 lets a round end through
    drain_and_write(16'd1);
    send_item(make_sample(3'd2, rand64(), 1'b1));
    send_item(make_sample(3'd5, rand64(), 1'b0));
    send_item(make_query(3'd2, rand64(), 3'd5, rand64()));
    drain_and_write(16'd0);
    send_item(make_sample(3'd4, rand64(), 1'b1));
    drain_and_write(16'hffff);
    send_item(make_sample(3'd4, rand64(), 1'b1));
  endtask

  task automatic random_items(int count);
    tsc_in_t it;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 55) begin
        it = make_query(3'($urandom()), rand64(), 3'($urandom()), rand64());
        if ($urandom_range(9) == 0) it.stamp = it.other_stamp;
      end else begin
        it = make_sample(3'($urandom()), rand64(), $urandom_range(29) == 0);
        if ($urandom_range(3) == 0) it.stamp = {32'd0, $urandom()};
      end
      send_item(it);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      random_items(20);
    join
  endtask

  initial begin
    for (int i = 0; i < NCPU; i++) stamps[i] = '0;
    for (int i = 0; i < NCPU*NCPU; i++) skew[i] = 64'd1;
    rounds = '0;
    limit = ROUND_LIMIT_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 13; recv_idle_pct = 48;
    test_directed();
    test_limit_extremes();
    drain_and_write(16'd30);
    random_items(270);
    send_idle_pct = 48; recv_idle_pct = 13;
    test_backpressure();
    random_items(250);
    drain_and_write(16'd1000);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_items(260);
    while (pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d results checked, %0d round updates, %0d ignored samples",
             n_results, n_updates, n_ignored);
    $display("limit written at 0, 1, 30, 1000 and 65535; long receiver hold-off done");
    if (mismatches == 0 && pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+design
design/tsc_pkg.sv
design/tsc_ram.sv
design/tsc_div.sv
design/timestamp_skew_calibrator.sv
design/tsc_checker.sv
sim/tb_timestamp_skew_calibrator.sv
